FILE: rtl/tsv_pkg.sv
// ----------------------------------------------------------------------------
// tsv_pkg
// Shared constants and types for the text stream visualizer: register
// indexes, character codes and the layout of the display-byte tail.
// ----------------------------------------------------------------------------
package tsv_pkg;

  // Configuration register indexes.
  localparam logic [2:0] CFG_NUMBER_ALL       = 3'd0;
  localparam logic [2:0] CFG_NUMBER_NONBLANK  = 3'd1;
  localparam logic [2:0] CFG_SQUEEZE_BLANK    = 3'd2;
  localparam logic [2:0] CFG_SHOW_ENDS        = 3'd3;
  localparam logic [2:0] CFG_SHOW_TABS        = 3'd4;
  localparam logic [2:0] CFG_SHOW_NONPRINTING = 3'd5;

  // Character codes.
  localparam logic [7:0] CH_TAB    = 8'h09;
  localparam logic [7:0] CH_NL     = 8'h0A;
  localparam logic [7:0] CH_SPACE  = 8'h20;
  localparam logic [7:0] CH_DOLLAR = 8'h24;
  localparam logic [7:0] CH_DASH   = 8'h2D;
  localparam logic [7:0] CH_QMARK  = 8'h3F;
  localparam logic [7:0] CH_UPPER_I = 8'h49;
  localparam logic [7:0] CH_UPPER_M = 8'h4D;
  localparam logic [7:0] CH_CARET  = 8'h5E;
  localparam logic [6:0] CH_DEL    = 7'h7F;
  localparam logic [3:0] DIGIT_HI  = 4'h3;

  // Line numbers are padded to at least this many characters.
  localparam int unsigned NUM_MIN_WIDTH = 6;

  // Longest display form of the byte itself, after any line number.
  localparam int unsigned TAIL_MAX = 4;

  typedef logic [7:0] byte_t;
  typedef logic [2:0] tail_len_t;

  // Register settings.
  typedef struct packed {
    logic number_all;
    logic number_nonblank;
    logic squeeze_blank;
    logic show_ends;
    logic show_tabs;
    logic show_nonprinting;
  } cfg_t;

endpackage

FILE: rtl/text_stream_visualizer_top.sv
// ----------------------------------------------------------------------------
// text_stream_visualizer_top
// Byte stream display filter: line numbering, blank-line squeezing and
// visible tabs, line ends and non-printing bytes.
// ----------------------------------------------------------------------------
//
//  Channel   Direction  Payload
//  s_axis    in         tdata[7:0] = in_byte
//  m_axis    out        tdata[7:0] = out_byte, tlast = last_of_run
//  cfg       in         cfg_idx_i selects a register, cfg_wdata_i[0] is stored
//
//  An input beat that expands to N output bytes occupies the job register until
//  its last byte leaves, and while m_axis_tready holds high the block sustains
//  one output byte per cycle; N runs from 1 to LINE_DIGITS + 5 and a squeezed
//  newline produces no output byte. Beats pass the job register, then the output register.
//  A stalled output holds the output register, then the job register, and
//  then s_axis_tready drops. Reset clears settings, line state and counter.
//
module text_stream_visualizer_top #(
  parameter int unsigned LINE_DIGITS = 10
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       s_axis_tvalid,
  output logic       s_axis_tready,
  input  logic [7:0] s_axis_tdata,   // [7:0] in_byte
  output logic       m_axis_tvalid,
  input  logic       m_axis_tready,
  output logic [7:0] m_axis_tdata,   // [7:0] out_byte
  output logic       m_axis_tlast,
  input  logic       cfg_we_i,
  input  logic [2:0] cfg_idx_i,
  input  logic       cfg_wdata_i
);

  localparam int unsigned CW = $clog2(LINE_DIGITS + 1);
  localparam int unsigned SW = $clog2(LINE_DIGITS + 6);
  localparam int unsigned IW = $clog2(LINE_DIGITS);

  tsv_pkg::cfg_t cfg_q;

  logic       prev_nl_q;
  logic [1:0] blank_run_q, blank_run_d;
  logic [3:0] line_digits_q [LINE_DIGITS];
  logic [3:0] line_digits_d [LINE_DIGITS];

  logic                 job_valid_q, job_valid_d;
  logic                 job_num_q;
  logic [3:0]           job_digits_q [LINE_DIGITS];
  tsv_pkg::byte_t       tail_q [tsv_pkg::TAIL_MAX];
  tsv_pkg::byte_t       tail_d [tsv_pkg::TAIL_MAX];
  tsv_pkg::tail_len_t   tail_len_q, tail_len_d;
  logic [SW-1:0]        step_q;

  logic           out_valid_q;
  tsv_pkg::byte_t out_byte_q;
  logic           out_last_q;

  // ---------------------------------------------------------------- config
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q <= '0;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        tsv_pkg::CFG_NUMBER_ALL:       cfg_q.number_all       <= cfg_wdata_i;
        tsv_pkg::CFG_NUMBER_NONBLANK:  cfg_q.number_nonblank  <= cfg_wdata_i;
        tsv_pkg::CFG_SQUEEZE_BLANK:    cfg_q.squeeze_blank    <= cfg_wdata_i;
        tsv_pkg::CFG_SHOW_ENDS:        cfg_q.show_ends        <= cfg_wdata_i;
        tsv_pkg::CFG_SHOW_TABS:        cfg_q.show_tabs        <= cfg_wdata_i;
        tsv_pkg::CFG_SHOW_NONPRINTING: cfg_q.show_nonprinting <= cfg_wdata_i;
        default: ;
      endcase
    end
  end

  // ---------------------------------------------------------------- handshake
  logic emit_fire, emit_last, job_done, in_fire;

  assign emit_fire     = job_valid_q && (!out_valid_q || m_axis_tready);
  assign job_done      = emit_fire && emit_last;
  assign s_axis_tready = !job_valid_q || job_done;
  assign in_fire       = s_axis_tvalid && s_axis_tready;

  // ---------------------------------------------------------------- input side
  logic       is_nl, is_tab, squeezed, numbering, add_num;
  logic       all_nine, carry;
  logic [6:0] lo7;
  logic [7:0] ctl0, ctl1;
  logic [1:0] ctl_len;

  always_comb begin
    is_nl  = (s_axis_tdata == tsv_pkg::CH_NL);
    is_tab = (s_axis_tdata == tsv_pkg::CH_TAB);

    if (is_nl && prev_nl_q) begin
      blank_run_d = (blank_run_q == 2'd3) ? blank_run_q : blank_run_q + 2'd1;
    end else begin
      blank_run_d = 2'd0;
    end
    squeezed = cfg_q.squeeze_blank && (blank_run_d > 2'd1);

    numbering = cfg_q.number_nonblank ? !is_nl : cfg_q.number_all;
    add_num   = !squeezed && prev_nl_q && numbering;

    // BCD increment that sticks at all nines.
    all_nine = 1'b1;
    for (int i = 0; i < LINE_DIGITS; i++) begin
      if (line_digits_q[i] != 4'd9) all_nine = 1'b0;
    end
    carry = !all_nine;
    for (int i = 0; i < LINE_DIGITS; i++) begin
      if (carry && line_digits_q[i] >= 4'd9) begin
        line_digits_d[i] = 4'd0;
      end else if (carry) begin
        line_digits_d[i] = line_digits_q[i] + 4'd1;
        carry = 1'b0;
      end else begin
        line_digits_d[i] = line_digits_q[i];
      end
    end

    // Caret form of the low seven bits.
    lo7 = s_axis_tdata[6:0];
    if (lo7 == tsv_pkg::CH_DEL) begin
      ctl0    = tsv_pkg::CH_CARET;
      ctl1    = tsv_pkg::CH_QMARK;
      ctl_len = 2'd2;
    end else if (lo7 < 7'd32) begin
      ctl0    = tsv_pkg::CH_CARET;
      ctl1    = {3'b010, lo7[4:0]};
      ctl_len = 2'd2;
    end else begin
      ctl0    = {1'b0, lo7};
      ctl1    = '0;
      ctl_len = 2'd1;
    end

    for (int i = 0; i < tsv_pkg::TAIL_MAX; i++) tail_d[i] = '0;
    if (cfg_q.show_tabs && is_tab) begin
      tail_d[0]  = tsv_pkg::CH_CARET;
      tail_d[1]  = tsv_pkg::CH_UPPER_I;
      tail_len_d = 3'd2;
    end else if (cfg_q.show_ends && is_nl) begin
      tail_d[0]  = tsv_pkg::CH_DOLLAR;
      tail_d[1]  = tsv_pkg::CH_NL;
      tail_len_d = 3'd2;
    end else if (cfg_q.show_nonprinting && !is_tab && !is_nl) begin
      if (s_axis_tdata[7]) begin
        tail_d[0]  = tsv_pkg::CH_UPPER_M;
        tail_d[1]  = tsv_pkg::CH_DASH;
        tail_d[2]  = ctl0;
        tail_d[3]  = ctl1;
        tail_len_d = {1'b0, ctl_len} + 3'd2;
      end else begin
        tail_d[0]  = ctl0;
        tail_d[1]  = ctl1;
        tail_len_d = {1'b0, ctl_len};
      end
    end else begin
      tail_d[0]  = s_axis_tdata;
      tail_len_d = 3'd1;
    end
  end

  always_comb begin
    job_valid_d = job_valid_q;
    if (in_fire) begin
      job_valid_d = !squeezed;
    end else if (job_done) begin
      job_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      prev_nl_q   <= 1'b1;
      blank_run_q <= 2'd0;
      job_valid_q <= 1'b0;
      step_q      <= '0;
      for (int i = 0; i < LINE_DIGITS; i++) line_digits_q[i] <= 4'd0;
    end else begin
      job_valid_q <= job_valid_d;
      if (in_fire) begin
        prev_nl_q   <= is_nl;
        blank_run_q <= blank_run_d;
        step_q      <= '0;
        if (add_num) line_digits_q <= line_digits_d;
      end else if (emit_fire) begin
        step_q <= step_q + 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_fire) begin
      job_num_q  <= add_num;
      tail_q     <= tail_d;
      tail_len_q <= tail_len_d;
      if (add_num) job_digits_q <= line_digits_d;
    end
  end

  // ---------------------------------------------------------------- emitter
  logic [CW-1:0]  top, width;
  logic [SW-1:0]  num_len, total_len, pos, tail_off;
  tsv_pkg::byte_t emit_byte;

  always_comb begin
    top = '0;
    for (int i = 0; i < LINE_DIGITS; i++) begin
      if (job_digits_q[i] != 4'd0) top = CW'(i);
    end
    width     = (top + 1'b1 > CW'(tsv_pkg::NUM_MIN_WIDTH)) ? top + 1'b1
                                                           : CW'(tsv_pkg::NUM_MIN_WIDTH);
    num_len   = job_num_q ? SW'(width) + 1'b1 : '0;
    total_len = num_len + SW'(tail_len_q);
    emit_last = (step_q == total_len - 1'b1);
    pos       = SW'(width) - 1'b1 - step_q;
    tail_off  = step_q - num_len;

    if (step_q < num_len) begin
      if (step_q == SW'(width)) begin
        emit_byte = tsv_pkg::CH_TAB;
      end else if (pos > SW'(top)) begin
        emit_byte = tsv_pkg::CH_SPACE;
      end else begin
        emit_byte = {tsv_pkg::DIGIT_HI, job_digits_q[pos[IW-1:0]]};
      end
    end else begin
      emit_byte = tail_q[tail_off[1:0]];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (emit_fire) begin
      out_valid_q <= 1'b1;
    end else if (m_axis_tready) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (emit_fire) begin
      out_byte_q <= emit_byte;
      out_last_q <= emit_last;
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = out_byte_q;
  assign m_axis_tlast  = out_last_q;

`ifndef SYNTHESIS
  logic digits_bcd;
  always_comb begin
    digits_bcd = 1'b1;
    for (int i = 0; i < LINE_DIGITS; i++) begin
      if (line_digits_q[i] > 4'd9) digits_bcd = 1'b0;
    end
  end

  a_step_in_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    job_valid_q |-> (step_q < total_len))
    else $error("emit step ran past the end of the job");

  a_tail_len: assert property (@(posedge clk_i) disable iff (!rst_ni)
    job_valid_q |-> (tail_len_q != 3'd0 && tail_len_q <= 3'd4))
    else $error("bad tail length in job register");

  a_no_overwrite: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_fire && job_valid_q) |-> job_done)
    else $error("job register overwritten before its last byte left");

  a_counter_bcd: assert property (@(posedge clk_i) disable iff (!rst_ni)
    digits_bcd)
    else $error("line counter holds a non-decimal digit");
`endif

endmodule
